// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mevq_pkg.sv =====
// types, constants and helper functions of the mouse event queue
`timescale 1ns / 1ps

package mevq_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_WRAP = 2'd2;

    // configuration reset values
    localparam logic [7:0]  MOVE_MASK_RST  = 8'd1;
    localparam logic [7:0]  WHEEL_MASK_RST = 8'd128;
    localparam logic [31:0] TIMER_WRAP_RST = 32'hFFFF_FFFF;

    localparam logic [15:0] LOST_MAX = 16'hFFFF;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED  = 3'd0,
        ST_MERGED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_POPPED  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // controller states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_ctl_state;

    // one stored event
    typedef struct packed {
        logic [7:0]         flags;
        logic signed [15:0] wheel;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [31:0]        tdiff;
        logic [31:0]        tstamp;
    } t_entry;

    // input item
    typedef struct packed {
        logic               command;
        logic [7:0]         event_flags;
        logic signed [15:0] wheel_position;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [31:0]        time_now;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         out_flags;
        logic signed [15:0] out_wheel;
        logic signed [15:0] out_dx;
        logic signed [15:0] out_dy;
        logic [31:0]        out_time_diff;
        logic [31:0]        out_time;
        logic [4:0]         events_held;
        logic [15:0]        lost_events;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    // signed 16-bit add that clips at the range limits
    function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
        logic [16:0] s;
        s = {a[15], a} + {b[15], b};
        if (s[16] != s[15]) begin
            return s[16] ? 16'sh8000 : 16'sh7FFF;
        end
        return s[15:0];
    endfunction

    // ring index advance
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

endpackage

// ===== hw/rtl/mevq_in_if.sv =====
// input channel of the mouse event queue
`timescale 1ns / 1ps

interface mevq_in_if;
    logic               valid;
    logic               ready;
    mevq_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mevq_out_if.sv =====
// result channel of the mouse event queue
`timescale 1ns / 1ps

interface mevq_out_if;
    logic                valid;
    logic                ready;
    mevq_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mevq_datapath.sv =====
// event store, configuration registers, ring pointers, counters and result register
`timescale 1ns / 1ps

module mevq_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mevq_pkg::t_dp_cmd                      i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [mevq_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [31:0]                            i_cfg_wdata,
    input  mevq_pkg::t_in_item                     i_item,
    output mevq_pkg::t_out_item                    o_item
);

    // configuration registers
    logic [7:0]  r_move_mask;
    logic [7:0]  r_wheel_mask;
    logic [31:0] r_timer_wrap;

    // event store
    mevq_pkg::t_entry r_mem [mevq_pkg::DEPTH];
    mevq_pkg::t_entry r_rd;

    // ring pointers and counters
    logic [mevq_pkg::IDX_W-1:0] r_head, n_head;
    logic [mevq_pkg::IDX_W-1:0] r_tail, n_tail;
    logic [mevq_pkg::CNT_W-1:0] r_count, n_count;
    logic [31:0]                r_last, n_last;
    logic [15:0]                r_lost, n_lost;

    // captured item
    logic                r_cmd;
    logic [7:0]          r_flags;
    logic signed [15:0]  r_wz;
    logic signed [15:0]  r_mx;
    logic signed [15:0]  r_my;
    logic                r_moving;
    logic [31:0]         r_now;
    logic [31:0]         r_gap;
    logic                r_before;
    logic [31:0]         r_wrap_p1;

    // result register
    mevq_pkg::t_out_item r_out, n_out;

    // memory write port
    logic                       mem_we;
    logic [mevq_pkg::IDX_W-1:0] mem_waddr;
    mevq_pkg::t_entry           mem_wdata;

    logic wheel_hit;
    logic move_hit;
    logic merge_hit;
    logic [31:0] tdiff;

    assign wheel_hit = |(i_item.event_flags & r_wheel_mask);
    assign move_hit  = |(i_item.event_flags & r_move_mask);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_mask  <= mevq_pkg::MOVE_MASK_RST;
            r_wheel_mask <= mevq_pkg::WHEEL_MASK_RST;
            r_timer_wrap <= mevq_pkg::TIMER_WRAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mevq_pkg::CFG_MOVE_MASK:  r_move_mask  <= i_cfg_wdata[7:0];
                mevq_pkg::CFG_WHEEL_MASK: r_wheel_mask <= i_cfg_wdata[7:0];
                mevq_pkg::CFG_TIMER_WRAP: r_timer_wrap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // capture the item, mask its fields and pre-compute the time gap
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd     <= i_item.command;
            r_flags   <= i_item.event_flags;
            r_wz      <= wheel_hit ? i_item.wheel_position : 16'sd0;
            r_mx      <= move_hit ? i_item.move_x : 16'sd0;
            r_my      <= move_hit ? i_item.move_y : 16'sd0;
            r_moving  <= move_hit;
            r_now     <= i_item.time_now;
            r_gap     <= i_item.time_now - r_last;
            r_before  <= r_last > i_item.time_now;
            r_wrap_p1 <= r_timer_wrap + 32'd1;
        end
    end

    // store: registered read at capture, single write at execute
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_rd <= r_mem[(i_item.command == mevq_pkg::CMD_POP) ? r_head : r_tail];
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    assign merge_hit = r_moving && (r_count != '0) && (r_rd.wheel == r_wz)
                       && (r_rd.flags == r_flags);
    assign tdiff     = r_before ? (r_gap + r_wrap_p1) : r_gap;

    // execute the captured command
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_last    = r_last;
        n_lost    = r_lost;
        mem_we    = 1'b0;
        mem_waddr = r_tail;
        mem_wdata = r_rd;
        n_out     = '0;

        if (r_cmd == mevq_pkg::CMD_POP) begin
            if (r_count == '0) begin
                n_out.status = mevq_pkg::ST_EMPTY;
            end else begin
                n_head             = mevq_pkg::next_idx(r_head);
                n_count            = r_count - 1'b1;
                n_out.status       = mevq_pkg::ST_POPPED;
                n_out.out_flags    = r_rd.flags;
                n_out.out_wheel    = r_rd.wheel;
                n_out.out_dx       = r_rd.dx;
                n_out.out_dy       = r_rd.dy;
                n_out.out_time_diff = r_rd.tdiff;
                n_out.out_time     = r_rd.tstamp;
            end
        end else if (merge_hit) begin
            mem_we       = i_cmd.execute;
            mem_wdata.dx = mevq_pkg::sat_add16(r_rd.dx, r_mx);
            mem_wdata.dy = mevq_pkg::sat_add16(r_rd.dy, r_my);
            n_out.status = mevq_pkg::ST_MERGED;
        end else if (r_count != mevq_pkg::CNT_W'(mevq_pkg::DEPTH)) begin
            n_tail           = mevq_pkg::next_idx(r_tail);
            mem_we           = i_cmd.execute;
            mem_waddr        = n_tail;
            mem_wdata.flags  = r_flags;
            mem_wdata.wheel  = r_wz;
            mem_wdata.dx     = r_mx;
            mem_wdata.dy     = r_my;
            mem_wdata.tdiff  = tdiff;
            mem_wdata.tstamp = r_now;
            n_last           = r_now;
            n_count          = r_count + 1'b1;
            n_out.status     = mevq_pkg::ST_STORED;
        end else begin
            if (r_lost != mevq_pkg::LOST_MAX) begin
                n_lost = r_lost + 16'd1;
            end
            n_out.status = mevq_pkg::ST_DROPPED;
        end

        n_out.events_held = 5'(n_count);
        n_out.lost_events = n_lost;
    end

    // pointer and counter update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= mevq_pkg::IDX_W'(mevq_pkg::DEPTH - 1);
            r_count <= '0;
            r_last  <= '0;
            r_lost  <= '0;
        end else if (i_cmd.execute) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_last  <= n_last;
            r_lost  <= n_lost;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

// ===== hw/rtl/mevq_ctrl.sv =====
// controller: item sequencing and result register handshake
`timescale 1ns / 1ps

module mevq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mevq_pkg::t_dp_cmd o_cmd
);

    mevq_pkg::t_ctl_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    // state and result valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mevq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            mevq_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = mevq_pkg::S_EXEC;
                end
            end
            mevq_pkg::S_EXEC: begin
                // wait until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = mevq_pkg::S_IDLE;
                end
            end
            default: n_state = mevq_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/mouse_event_queue_with_merge.sv =====
// top level of the mouse event queue with motion merging
// an accepted item is captured with a registered read of the event store; the update edge then
// writes its result register, and the next item is taken only once that update is done;
// a stalled result register holds the update back
// reset: synchronous active low; clears pointers, counters, last time and configuration,
// the event store itself is not cleared
`timescale 1ns / 1ps

module mouse_event_queue_with_merge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mevq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_wdata,
    mevq_in_if.sink                        i_in,
    mevq_out_if.source                     o_out
);

    mevq_pkg::t_dp_cmd cmd;

    // sequencing
    mevq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // store and arithmetic
    mevq_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_in.payload),
        .o_item      (o_out.payload)
    );

endmodule

// ===== hw/rtl/mevq_checker.sv =====
// port-level checks of the mouse event queue and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mevq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input mevq_pkg::t_out_item i_out_payload
);

    logic is_popped;
    logic is_empty;
    logic is_dropped;
    logic data_zero;

    assign is_popped  = i_out_payload.status == mevq_pkg::ST_POPPED;
    assign is_empty   = i_out_payload.status == mevq_pkg::ST_EMPTY;
    assign is_dropped = i_out_payload.status == mevq_pkg::ST_DROPPED;
    assign data_zero  = (i_out_payload.out_flags == '0) && (i_out_payload.out_wheel == '0)
                        && (i_out_payload.out_dx == '0) && (i_out_payload.out_dy == '0)
                        && (i_out_payload.out_time_diff == '0)
                        && (i_out_payload.out_time == '0);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_rst_n && i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload), "result changed while stalled")

    // the fill level never passes the depth
    `ASSERT_ALWAYS(a_held_max, i_clk, i_rst_n, !i_out_valid || (i_out_payload.events_held <= 5'(mevq_pkg::DEPTH)), "fill level above depth")

    // only a pop carries entry data
    `ASSERT_ALWAYS(a_data_zero, i_clk, i_rst_n, !i_out_valid || is_popped || data_zero, "entry data on a non-pop result")

    // an empty pop sees an empty queue
    `ASSERT_ALWAYS(a_empty_lvl, i_clk, i_rst_n, !i_out_valid || !is_empty || (i_out_payload.events_held == '0), "empty status with entries held")

    // a drop only happens when full, with a nonzero lost count
    `ASSERT_ALWAYS(a_drop_full, i_clk, i_rst_n, !i_out_valid || !is_dropped || ((i_out_payload.events_held == 5'(mevq_pkg::DEPTH)) && (i_out_payload.lost_events != '0)), "drop while not full")

endmodule

bind mouse_event_queue_with_merge mevq_checker u_mevq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

// ===== verif/tb_mouse_event_queue_with_merge.sv =====
// self-checking testbench for the mouse event queue with motion merging
`timescale 1ns / 1ps

module tb_mouse_event_queue_with_merge;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int LOST_ITEMS  = 40;

    // tracks queue contents and counters, and holds the results still owed
    class event_queue_tracker;
        mevq_pkg::t_entry                    slots [mevq_pkg::DEPTH];
        logic [mevq_pkg::IDX_W-1:0]          head_pos;
        logic [mevq_pkg::IDX_W-1:0]          tail_pos;
        logic [mevq_pkg::CNT_W-1:0]          held;
        logic [31:0]                         last_stamp;
        logic [15:0]                         lost;
        logic [7:0]                          move_mask;
        logic [7:0]                          wheel_mask;
        logic [31:0]                         wrap_value;
        mevq_pkg::t_out_item                 awaited [$];
        int                                  fail_count;

        function new();
            head_pos   = '0;
            tail_pos   = mevq_pkg::IDX_W'(mevq_pkg::DEPTH - 1);
            held       = '0;
            last_stamp = '0;
            lost       = '0;
            move_mask  = mevq_pkg::MOVE_MASK_RST;
            wheel_mask = mevq_pkg::WHEEL_MASK_RST;
            wrap_value = mevq_pkg::TIMER_WRAP_RST;
            fail_count = 0;
        endfunction

        function void write_reg(input logic [mevq_pkg::CFG_IDX_W-1:0] idx,
                                input logic [31:0] data);
            case (idx)
                mevq_pkg::CFG_MOVE_MASK:  move_mask  = data[7:0];
                mevq_pkg::CFG_WHEEL_MASK: wheel_mask = data[7:0];
                mevq_pkg::CFG_TIMER_WRAP: wrap_value = data;
                default: ;
            endcase
        endfunction

        // motion sum clipped to the 16-bit signed range
        function logic signed [15:0] clip_add(input logic signed [15:0] a,
                                              input logic signed [15:0] b);
            int s;
            s = int'(a) + int'(b);
            if (s > 32767) return 16'sh7FFF;
            if (s < -32768) return 16'sh8000;
            return 16'(s);
        endfunction

        function logic [mevq_pkg::IDX_W-1:0] ring_next(input logic [mevq_pkg::IDX_W-1:0] i);
            return (int'(i) == mevq_pkg::DEPTH - 1) ? '0 : i + 1'b1;
        endfunction

        // apply one item to the tracked queue and return the result it yields
        function mevq_pkg::t_out_item apply_item(input mevq_pkg::t_in_item it);
            mevq_pkg::t_out_item        r;
            mevq_pkg::t_entry           e;
            logic signed [15:0]         wz;
            logic signed [15:0]         mx;
            logic signed [15:0]         my;
            logic                       moving;
            logic [mevq_pkg::IDX_W-1:0] nt;
            logic [31:0]                now;
            r = '0;
            if (it.command == mevq_pkg::CMD_POP) begin
                if (held == 0) begin
                    r.status = mevq_pkg::ST_EMPTY;
                end else begin
                    e = slots[head_pos];
                    r.out_flags     = e.flags;
                    r.out_wheel     = e.wheel;
                    r.out_dx        = e.dx;
                    r.out_dy        = e.dy;
                    r.out_time_diff = e.tdiff;
                    r.out_time      = e.tstamp;
                    head_pos = ring_next(head_pos);
                    held     = held - 1'b1;
                    r.status = mevq_pkg::ST_POPPED;
                end
            end else begin
                wz     = ((it.event_flags & wheel_mask) != 0) ? it.wheel_position : 16'sd0;
                moving = (it.event_flags & move_mask) != 0;
                mx     = moving ? it.move_x : 16'sd0;
                my     = moving ? it.move_y : 16'sd0;
                now    = it.time_now;
                if (moving && held != 0 && slots[tail_pos].wheel == wz
                        && slots[tail_pos].flags == it.event_flags) begin
                    // same gesture as the newest entry: fold motion in
                    slots[tail_pos].dx = clip_add(slots[tail_pos].dx, mx);
                    slots[tail_pos].dy = clip_add(slots[tail_pos].dy, my);
                    r.status = mevq_pkg::ST_MERGED;
                end else if (held < mevq_pkg::DEPTH) begin
                    nt      = ring_next(tail_pos);
                    e.flags = it.event_flags;
                    e.wheel = wz;
                    e.dx    = mx;
                    e.dy    = my;
                    // timer ran backwards means it wrapped at the wrap value
                    e.tdiff = (last_stamp <= now) ? now - last_stamp
                                                  : wrap_value - last_stamp + 32'd1 + now;
                    e.tstamp      = now;
                    slots[nt]     = e;
                    last_stamp    = now;
                    tail_pos      = nt;
                    held          = held + 1'b1;
                    r.status      = mevq_pkg::ST_STORED;
                end else begin
                    if (lost != mevq_pkg::LOST_MAX) lost = lost + 1'b1;
                    r.status = mevq_pkg::ST_DROPPED;
                end
            end
            r.events_held = 5'(held);
            r.lost_events = lost;
            return r;
        endfunction

        function void note_item(input mevq_pkg::t_in_item it);
            awaited.push_back(apply_item(it));
        endfunction

        function void check_field(input string name, input logic signed [32:0] want,
                                  input logic signed [32:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(input mevq_pkg::t_out_item got);
            mevq_pkg::t_out_item want;
            if (awaited.size() == 0) begin
                $error("result with no item pending, status %0d", got.status);
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            check_field("status",        want.status,        got.status);
            check_field("out_flags",     want.out_flags,     got.out_flags);
            check_field("out_wheel",     want.out_wheel,     got.out_wheel);
            check_field("out_dx",        want.out_dx,        got.out_dx);
            check_field("out_dy",        want.out_dy,        got.out_dy);
            check_field("out_time_diff", want.out_time_diff, got.out_time_diff);
            check_field("out_time",      want.out_time,      got.out_time);
            check_field("events_held",   want.events_held,   got.events_held);
            check_field("lost_events",   want.lost_events,   got.lost_events);
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [mevq_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]                    i_cfg_wdata;

    mevq_in_if  in_ch ();
    mevq_out_if out_ch ();

    mouse_event_queue_with_merge u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    event_queue_tracker tracker = new();

    int unsigned cycle_count = 0;
    int          burst_left  = 0;
    logic [7:0]  last_flags  = 8'h00;
    logic [15:0] last_wheel  = 16'h0000;
    logic [63:0] tick_now    = 64'd0;
    logic [15:0] rx_pattern  = 16'hFFFF;
    logic [5:0]  rx_tick     = 6'd0;

    // clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_mouse_event_queue_with_merge: FAIL");
            $finish;
        end
    end

    // accepted input items feed the tracker
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) tracker.note_item(in_ch.payload);
    end

    // accepted result items are checked
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) tracker.check_result(out_ch.payload);
    end

    // receiver stall pattern, re-rolled each time the 6-bit tick counter wraps
    always @(negedge i_clk) begin
        rx_tick = rx_tick + 1'b1;
        if (rx_tick == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    rx_pattern = 16'hFFFF;
                2:       rx_pattern = 16'($urandom);
                3:       rx_pattern = 16'($urandom) | 16'($urandom);
                default: rx_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
            endcase
        end
        out_ch.ready = rx_pattern[rx_tick[3:0]];
    end

    function automatic mevq_pkg::t_in_item push_ev(input logic [7:0] f,
                                                   input logic [15:0] wh,
                                                   input logic [15:0] x,
                                                   input logic [15:0] y,
                                                   input logic [31:0] stamp);
        mevq_pkg::t_in_item it;
        it.command        = mevq_pkg::CMD_PUSH;
        it.event_flags    = f;
        it.wheel_position = wh;
        it.move_x         = x;
        it.move_y         = y;
        it.time_now       = stamp;
        return it;
    endfunction

    function automatic mevq_pkg::t_in_item pop_req();
        mevq_pkg::t_in_item it;
        it = push_ev(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        it.command = mevq_pkg::CMD_POP;
        return it;
    endfunction

    function automatic logic [15:0] next_motion();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    // free-running timer that wraps at the configured value, with rare jumps
    function automatic logic [31:0] next_tick();
        logic [63:0] span;
        span = {32'd0, tracker.wrap_value} + 64'd1;
        if ($urandom_range(0, 24) == 0) return $urandom;
        tick_now = tick_now + 64'($urandom_range(0, 4000));
        if ($urandom_range(0, 19) == 0) tick_now = tick_now + 64'($urandom);
        tick_now = tick_now % span;
        return tick_now[31:0];
    endfunction

    // random item: a pop at the given rate, else gestures continuing the last event, fresh events and noise
    function automatic mevq_pkg::t_in_item next_random_item(input int pop_pct);
        mevq_pkg::t_in_item it;
        logic [7:0]         f;
        int                 kind;
        it = push_ev(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        if ($urandom_range(0, 99) < pop_pct) begin
            it.command = mevq_pkg::CMD_POP;
            return it;
        end
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            it.event_flags = last_flags;
            if ((last_flags & tracker.wheel_mask) != 0) it.wheel_position = last_wheel;
            it.move_x   = next_motion();
            it.move_y   = next_motion();
            it.time_now = next_tick();
        end else if (kind < 85) begin
            f = 8'($urandom);
            if ($urandom_range(0, 1) == 0) f = f | tracker.wheel_mask;
            else f = f & ~tracker.wheel_mask;
            if ($urandom_range(0, 9) < 7) f = f | tracker.move_mask;
            else f = f & ~tracker.move_mask;
            it.event_flags = f;
            case ($urandom_range(0, 3))
                0:       it.wheel_position = 16'h7FFF;
                1:       it.wheel_position = 16'h8000;
                2:       it.wheel_position = 16'($urandom);
                default: it.wheel_position = 16'($urandom_range(0, 15) - 8);
            endcase
            it.move_x   = next_motion();
            it.move_y   = next_motion();
            it.time_now = next_tick();
        end
        last_flags = it.event_flags;
        last_wheel = it.wheel_position;
        return it;
    endfunction

    // offer one item, in bursts with random gaps when asked
    task automatic send_item(input mevq_pkg::t_in_item it, input bit with_gaps);
        int gap;
        @(negedge i_clk);
        if (with_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // write all three registers once the queue has answered every item
    task automatic set_regs(input logic [7:0] m, input logic [7:0] w, input logic [31:0] t);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = mevq_pkg::CFG_MOVE_MASK;
        i_cfg_wdata = {24'd0, m};
        tracker.write_reg(mevq_pkg::CFG_MOVE_MASK, {24'd0, m});
        @(negedge i_clk);
        i_cfg_idx   = mevq_pkg::CFG_WHEEL_MASK;
        i_cfg_wdata = {24'd0, w};
        tracker.write_reg(mevq_pkg::CFG_WHEEL_MASK, {24'd0, w});
        @(negedge i_clk);
        i_cfg_idx   = mevq_pkg::CFG_TIMER_WRAP;
        i_cfg_wdata = t;
        tracker.write_reg(mevq_pkg::CFG_TIMER_WRAP, t);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        burst_left  = 0;
    endtask

    // stimulus
    initial begin
        mevq_pkg::t_in_item it;
        int                 ph;
        int                 n;
        int                 k;
        logic [7:0]         m;
        logic [7:0]         w;
        logic [31:0]        t;

        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = mevq_pkg::CFG_MOVE_MASK;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, masking, backwards timer, clipping merges, full queue
        send_item(pop_req(), 1'b1);
        send_item(push_ev(8'h00, 16'h7FFF, 16'h1234, 16'h4321, 32'd100), 1'b1);
        send_item(push_ev(8'h81, 16'h8000, 16'h7FFF, 16'h8000, 32'd50), 1'b1);
        send_item(push_ev(8'h81, 16'h8000, 16'h0001, 16'hFFFF, 32'd60), 1'b1);
        send_item(push_ev(8'h81, 16'h8000, 16'h8000, 16'h7FFF, 32'd70), 1'b1);
        send_item(push_ev(8'hFF, 16'h7FFF, 16'hFFFF, 16'h0001, 32'hFFFF_FFFF), 1'b1);
        send_item(pop_req(), 1'b1);
        for (k = 0; k < 14; k++) begin
            m = (k == 13) ? 8'h01 : (k[0] ? 8'h02 : 8'h40);
            send_item(push_ev(m, 16'(k * 4099), 16'(k), 16'(-k), 32'(1000 + k)), 1'b1);
        end
        send_item(push_ev(8'h02, 16'h0000, 16'h0000, 16'h0000, 32'd2000), 1'b1);
        send_item(push_ev(8'h01, 16'h5555, 16'h0005, 16'hFFFB, 32'd2001), 1'b1);

        // random phases under several register settings
        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin
                    m = mevq_pkg::MOVE_MASK_RST;
                    w = mevq_pkg::WHEEL_MASK_RST;
                    t = mevq_pkg::TIMER_WRAP_RST;
                end
                1:       begin m = 8'hFF; w = 8'hFF; t = 32'd0; end
                2:       begin m = 8'h00; w = 8'h00; t = 32'd1000; end
                3:       begin m = 8'h06; w = 8'h18; t = $urandom; end
                4:       begin m = 8'($urandom); w = 8'($urandom); t = $urandom_range(0, 9999); end
                5:       begin m = 8'h01; w = 8'h80; t = 32'h7FFF_FFFF; end
                6:       begin m = 8'h80; w = 8'h01; t = 32'h0000_FFFF; end
                default: begin m = 8'hFF; w = 8'h00; t = 32'hFFFF_FFFF; end
            endcase
            set_regs(m, w, t);
            tick_now = 64'd0;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                it = next_random_item(((n % 100) < 60) ? 25 : 65);
                send_item(it, 1'b1);
            end
        end

        // lost counter rises: no merging, queue kept full
        set_regs(8'h00, 8'h80, 32'hFFFF_FFFF);
        for (n = 0; n < LOST_ITEMS; n++) begin
            it = push_ev(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
            send_item(it, 1'b0);
        end
        for (n = 0; n < 20; n++) send_item(pop_req(), 1'b1);

        // drain and report
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.awaited.size() == 0) begin
            $display("tb_mouse_event_queue_with_merge: PASS");
        end else begin
            $display("tb_mouse_event_queue_with_merge: FAIL");
        end
        $finish;
    end

endmodule
